// ===== src/flrm_pkg.sv =====
package flrm_pkg;

  // Default size of the node pool, in 256-entry nodes.
  localparam int unsigned POOL_NODES_DEF = 64;

  // Entries per node; one key byte selects an entry.
  localparam int unsigned FANOUT = 256;

  // Width of one stored entry: a valid flag above 32 bits of child number or value.
  localparam int unsigned ENTRY_W = 33;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_CLEAR,
    S_LINK,
    S_LEAF
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        key;
    logic signed [31:0] store_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         nodes_in_use;
  } rsp_t;

endpackage

// ===== src/flrm_node_ram.sv =====
module flrm_node_ram #(
  parameter int unsigned AW = 14,
  parameter int unsigned DW = 33
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  // Simple dual-port store: one write and one registered read per cycle.
  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/four_level_radix_map_core.sv =====
// Channel   Direction  Handshake             Payload
// --------  ---------  --------------------  ------------------------------------------
// request   in         start high, busy low  req_i: command, key, store_value
// response  out        done_o for one cycle  rsp_o: read_value, status, nodes_in_use
//
// A get makes four dependent reads of the node memory, one per level, each after the first
// issued from the data of the read before it; a missing node ends it with a miss.
// A set reads levels up to the first missing one (three at most), checks the pool, clears
// all 256 entries of each node it allocates and links it, then writes the leaf; if the pool
// holds too few free nodes it answers full instead, before anything is written.
// Clear and the unused command answer in one cycle, the map is empty right after reset, and
// the receiver cannot stall: a new request may be accepted while a response word shows.
module four_level_radix_map_core #(
  parameter int unsigned POOL_NODES = flrm_pkg::POOL_NODES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  flrm_pkg::req_t  req_i,
  output logic            done_o,
  output flrm_pkg::rsp_t  rsp_o
);

  // Node numbers, node-memory addresses and the allocation counter.
  localparam int unsigned NW = $clog2(POOL_NODES);
  localparam int unsigned AW = NW + $clog2(flrm_pkg::FANOUT);
  localparam int unsigned CW = $clog2(POOL_NODES + 1);

  // Picks the key byte that indexes a given level; level 0 uses the top byte.
  function automatic logic [7:0] key_byte(input logic [31:0] k, input logic [1:0] l);
    logic [7:0] b;
    unique case (l)
      2'd0:    b = k[31:24];
      2'd1:    b = k[23:16];
      2'd2:    b = k[15:8];
      default: b = k[7:0];
    endcase
    return b;
  endfunction

  flrm_pkg::state_e state_q, state_d;
  logic [1:0]       lvl_q, lvl_d;
  logic [2:0]       depth_q, depth_d;
  logic [NW-1:0]    node_q, node_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [CW-1:0]    next_free_q, next_free_d;
  logic             root_q, root_d;
  logic             done_q, done_d;
  flrm_pkg::rsp_t   rsp_q, rsp_d;

  // Captured request fields.
  logic [31:0]      key_q;
  logic [31:0]      val_q;
  logic             is_set_q;

  // Node memory ports.
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [flrm_pkg::ENTRY_W-1:0]   mem_wdata;
  logic [AW-1:0]                  mem_raddr;
  logic [flrm_pkg::ENTRY_W-1:0]   mem_rdata;

  logic             accept;
  logic             entry_ok;
  logic [NW-1:0]    child;
  logic [NW-1:0]    new_node;
  logic [CW+2:0]    needed;
  logic [CW+2:0]    free_nodes;

  assign accept   = start && !busy;
  assign busy     = (state_q != flrm_pkg::S_IDLE);

  // An inner entry leads on only if it is marked valid and names a node of the pool.
  assign entry_ok = mem_rdata[32] && (mem_rdata[31:0] < 32'(POOL_NODES));
  assign child    = mem_rdata[NW-1:0];
  assign new_node = next_free_q[NW-1:0];

  // Nodes still to be allocated for this set, against nodes left in the pool.
  assign needed     = (CW + 3)'(3'd4 - depth_q);
  assign free_nodes = (CW + 3)'(CW'(POOL_NODES) - next_free_q);

  flrm_node_ram #(
    .AW (AW),
    .DW (flrm_pkg::ENTRY_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    depth_d     = depth_q;
    node_d      = node_q;
    cnt_d       = cnt_q;
    next_free_d = next_free_q;
    root_d      = root_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = {node_q, key_byte(key_q, lvl_q)};

    unique case (state_q)
      flrm_pkg::S_IDLE: begin
        // The root is always pool node zero, so the first read needs no lookup.
        mem_raddr = {NW'(0), req_i.key[31:24]};
        if (accept) begin
          lvl_d  = 2'd0;
          node_d = '0;
          unique case (req_i.command)
            flrm_pkg::CMD_GET: begin
              if (root_q) begin
                state_d = flrm_pkg::S_WALK;
              end else begin
                done_d           = 1'b1;
                rsp_d.read_value = '1;
                rsp_d.status     = flrm_pkg::ST_MISS;
              end
            end
            flrm_pkg::CMD_SET: begin
              if (root_q) begin
                state_d = flrm_pkg::S_WALK;
              end else begin
                depth_d = 3'd0;
                state_d = flrm_pkg::S_CHECK;
              end
            end
            flrm_pkg::CMD_CLEAR: begin
              root_d           = 1'b0;
              next_free_d      = '0;
              done_d           = 1'b1;
              rsp_d.read_value = '0;
              rsp_d.status     = flrm_pkg::ST_DONE;
            end
            default: begin
              done_d           = 1'b1;
              rsp_d.read_value = '0;
              rsp_d.status     = flrm_pkg::ST_DONE;
            end
          endcase
        end
      end

      flrm_pkg::S_WALK: begin
        if (lvl_q == 2'd3) begin
          // Only a get reads the leaf entry.
          done_d           = 1'b1;
          rsp_d.read_value = mem_rdata[31:0];
          rsp_d.status     = flrm_pkg::ST_DONE;
          state_d          = flrm_pkg::S_IDLE;
        end else if (entry_ok) begin
          node_d = child;
          if (is_set_q && (lvl_q == 2'd2)) begin
            depth_d = 3'd4;
            state_d = flrm_pkg::S_CHECK;
          end else begin
            lvl_d     = lvl_q + 2'd1;
            mem_raddr = {child, key_byte(key_q, lvl_q + 2'd1)};
          end
        end else if (is_set_q) begin
          // The node at this level exists; everything below it is missing.
          depth_d = 3'(lvl_q) + 3'd1;
          state_d = flrm_pkg::S_CHECK;
        end else begin
          done_d           = 1'b1;
          rsp_d.read_value = '1;
          rsp_d.status     = flrm_pkg::ST_MISS;
          state_d          = flrm_pkg::S_IDLE;
        end
      end

      flrm_pkg::S_CHECK: begin
        cnt_d = '0;
        if (needed > free_nodes) begin
          done_d           = 1'b1;
          rsp_d.read_value = '0;
          rsp_d.status     = flrm_pkg::ST_FULL;
          state_d          = flrm_pkg::S_IDLE;
        end else if (depth_q == 3'd4) begin
          state_d = flrm_pkg::S_LEAF;
        end else begin
          state_d = flrm_pkg::S_CLEAR;
        end
      end

      flrm_pkg::S_CLEAR: begin
        // Zero the node about to be handed out, one entry per cycle.
        mem_we    = 1'b1;
        mem_waddr = {new_node, cnt_q};
        mem_wdata = '0;
        cnt_d     = cnt_q + 8'd1;
        if (cnt_q == 8'hff) begin
          state_d = flrm_pkg::S_LINK;
        end
      end

      flrm_pkg::S_LINK: begin
        if (depth_q == 3'd0) begin
          root_d = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {node_q, key_byte(key_q, 2'(depth_q - 3'd1))};
          mem_wdata = {1'b1, 32'(new_node)};
        end
        node_d      = new_node;
        next_free_d = next_free_q + CW'(1);
        depth_d     = depth_q + 3'd1;
        if (depth_q == 3'd3) begin
          state_d = flrm_pkg::S_LEAF;
        end else begin
          state_d = flrm_pkg::S_CLEAR;
        end
      end

      flrm_pkg::S_LEAF: begin
        mem_we           = 1'b1;
        mem_waddr        = {node_q, key_q[7:0]};
        mem_wdata        = {1'b0, val_q};
        done_d           = 1'b1;
        rsp_d.read_value = '0;
        rsp_d.status     = flrm_pkg::ST_DONE;
        state_d          = flrm_pkg::S_IDLE;
      end

      default: begin
        state_d = flrm_pkg::S_IDLE;
      end
    endcase

    // The pool count always reports the state left behind by this word.
    if (done_d) begin
      rsp_d.nodes_in_use = 7'(next_free_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flrm_pkg::S_IDLE;
      lvl_q       <= '0;
      depth_q     <= '0;
      node_q      <= '0;
      cnt_q       <= '0;
      next_free_q <= '0;
      root_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      depth_q     <= depth_d;
      node_q      <= node_d;
      cnt_q       <= cnt_d;
      next_free_q <= next_free_d;
      root_q      <= root_d;
      done_q      <= done_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      key_q    <= req_i.key;
      val_q    <= req_i.store_value;
      is_set_q <= (req_i.command == flrm_pkg::CMD_SET);
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
